/* rtl/gb7_pkg.sv */
// ----------------------------------------------------------------------------
// gb7_pkg: shared types and constants of the 7x7 binomial blur
// Holds the pixel and result structs, the register indexes, the beat codes
// and the binomial tap weights that every lane uses.
// ----------------------------------------------------------------------------
package gb7_pkg;

  // Number of taps along one axis of the kernel.
  localparam int NumTaps = 7;
  // Bits of one packed RGBA pixel word.
  localparam int PixW = 32;
  // Normalization shift: the weights of the kernel sum to 4096.
  localparam int KernShift = 12;
  // Bits of a vertical column sum (255 * 64).
  localparam int VSumW = 14;
  // Bits of a full window sum (255 * 4096).
  localparam int HSumW = 20;

  // Beat codes.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_CHANNELS = 2'd2
  } cfg_idx_e;

  // One input beat.
  typedef struct packed {
    logic       opcode;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_t;

  // One blurred pixel.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_last;
  } out_t;

  // Binomial weights 1, 6, 15, 20, 15, 6, 1.
  function automatic logic [4:0] tap_weight(input logic [2:0] idx);
    logic [4:0] w;
    case (idx)
      3'd0:    w = 5'd1;
      3'd1:    w = 5'd6;
      3'd2:    w = 5'd15;
      3'd3:    w = 5'd20;
      3'd4:    w = 5'd15;
      3'd5:    w = 5'd6;
      3'd6:    w = 5'd1;
      default: w = 5'd0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/gb7_row_bank.sv */
// ----------------------------------------------------------------------------
// gb7_row_bank: one line store bank
// Single write port, single registered read port. A read of the address that
// is being written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module gb7_row_bank
  import gb7_pkg::*;
#(
  parameter int Depth = 1024,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [PixW-1:0]  wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [PixW-1:0]  rd_data_o
);

  logic [PixW-1:0] mem [Depth];
  logic [PixW-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port with write-through on an address match.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/gb7_lane.sv */
// ----------------------------------------------------------------------------
// gb7_lane: blur datapath for one color channel
// Forms the clamped vertical column sum from the seven bank bytes, keeps the
// last seven column sums in a shift line and forms the clamped horizontal sum.
// ----------------------------------------------------------------------------
module gb7_lane
  import gb7_pkg::*;
(
  input  logic       clk_i,
  input  logic       load_i,
  input  logic [7:0] bank_pix_i [NumTaps],
  input  logic [2:0] vsel_i [NumTaps],
  input  logic [1:0] hlo_i,
  input  logic [1:0] hhi_i,
  output logic [7:0] res_o
);

  logic [VSumW-1:0] vsum;
  logic [VSumW-1:0] line_q [NumTaps];
  logic [HSumW-1:0] hsum;

  // Vertical sum: each tap reads the bank that holds its clamped row.
  always_comb begin
    vsum = '0;
    for (int i = 0; i < NumTaps; i++) begin
      vsum = vsum + VSumW'(tap_weight(3'(i)) * bank_pix_i[vsel_i[i]]);
    end
  end

  // Shift line of column sums; entry zero is the newest column.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      line_q[0] <= vsum;
      for (int i = 1; i < NumTaps; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

  // Horizontal sum with the column offset clamped to the row edges.
  always_comb begin
    int dx;
    int lo;
    int hi;
    hsum = '0;
    lo = int'(hlo_i);
    hi = int'(hhi_i);
    for (int j = 0; j < NumTaps; j++) begin
      dx = j - 3;
      if (dx < -lo) dx = -lo;
      if (dx > hi) dx = hi;
      hsum = hsum + HSumW'(tap_weight(3'(j)) * line_q[3'(3 - dx)]);
    end
  end

  assign res_o = hsum[KernShift +: 8];

endmodule

/* rtl/gaussian_blur_7x7_unit.sv */
// ----------------------------------------------------------------------------
// gaussian_blur_7x7_unit: streaming 7x7 binomial blur
// Takes one pixel per clock in raster order and gives one blurred pixel per
// clock while the output is not held. Output pixel q is formed on the beat of
// input position q + 3*width + 3, then passes the bank read, line and output
// registers; 3*width + 3 drain beats flush the frame. Seven line store banks,
// one per row modulo seven, are read once and written at most once per clock,
// which sets the rate of one pixel per cycle. Four channel lanes work side by
// side; the output stage merges them and zeroes alpha in three-channel mode.
// ----------------------------------------------------------------------------
module gaussian_blur_7x7_unit
  import gb7_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CB = $clog2(MAX_WIDTH);
  localparam int PW = WW + 12;
  localparam int CW = (WW > 11) ? WW : 11;

  // Configuration registers.
  logic [10:0] image_width_q;
  logic [11:0] image_height_q;
  logic [2:0]  channel_count_q;

  // Frame geometry.
  logic [CW-1:0] w_raw;
  logic [WW-1:0] eff_w;
  logic [CB-1:0] w_m1;
  logic [11:0]   eff_h;
  logic [11:0]   h_m1;
  logic [PW-1:0] three_w;
  logic [PW-1:0] lag;
  logic [PW-1:0] total;
  logic          four_ch;

  // Position counters.
  logic [PW-1:0] pos_q;
  logic [CB-1:0] in_col_q;
  logic [2:0]    in_bank_q;
  logic [CB-1:0] v_col_q;
  logic [12:0]   v_row_q;
  logic [2:0]    v_bank_q;
  logic [CB-1:0] out_col_q;
  logic [11:0]   out_row_q;

  // Beat decode.
  logic en;
  logic accept;
  logic in_frame;
  logic is_drain;
  logic adv;
  logic wr;
  logic v_act;
  logic o_act;
  logic last0;

  // Clamp bounds and bank selects for the current token.
  logic [1:0]  vlo;
  logic [1:0]  vhi;
  logic [12:0] vdiff;
  logic [1:0]  hlo;
  logic [1:0]  hhi;
  logic [CB-1:0] hdiff;
  logic [2:0]  vsel [NumTaps];

  // Pipeline registers.
  logic        s1_valid_q;
  logic        s1_out_q;
  logic        s1_last_q;
  logic [1:0]  s1_hlo_q;
  logic [1:0]  s1_hhi_q;
  logic [2:0]  s1_vsel_q [NumTaps];
  logic        s2_valid_q;
  logic        s2_out_q;
  logic        s2_last_q;
  logic [1:0]  s2_hlo_q;
  logic [1:0]  s2_hhi_q;
  logic        out_valid_q;
  out_t        out_data_q;

  // Line store signals.
  logic [6:0]      bank_we;
  logic [PixW-1:0] wr_word;
  logic [PixW-1:0] bank_rd [NumTaps];
  logic [7:0]      lane_pix [4][NumTaps];
  logic [7:0]      lane_res [4];

  // Configuration writes; a write to a known register restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= 11'd640;
      image_height_q  <= 12'd480;
      channel_count_q <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:    image_width_q   <= cfg_data_i[10:0];
        CFG_HEIGHT:   image_height_q  <= cfg_data_i;
        CFG_CHANNELS: channel_count_q <= cfg_data_i[2:0];
        default:      ;
      endcase
    end
  end

  logic cfg_restart;
  assign cfg_restart = cfg_we_i && ((cfg_idx_i == CFG_WIDTH) ||
                       (cfg_idx_i == CFG_HEIGHT) || (cfg_idx_i == CFG_CHANNELS));

  // Effective width and height with out-of-range values folded in.
  always_comb begin
    w_raw = CW'(image_width_q);
    if (w_raw == '0) begin
      eff_w = WW'(1);
    end else if (w_raw > CW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(w_raw);
    end
    w_m1    = CB'(eff_w - WW'(1));
    eff_h   = (image_height_q == '0) ? 12'd1 : image_height_q;
    h_m1    = eff_h - 12'd1;
    three_w = PW'({eff_w, 1'b0}) + PW'(eff_w);
    lag     = three_w + PW'(3);
    four_ch = channel_count_q[2];
  end

  // Frame size; it follows a register write from the very next beat.
  assign total = PW'(eff_w) * PW'(eff_h);

  // Handshake and beat decode.
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;
  assign accept     = in_valid_i && en;
  assign is_drain   = (in_data_i.opcode == OP_DRAIN);
  assign in_frame   = (pos_q < total);
  assign adv        = accept && !(is_drain && in_frame);
  assign wr         = accept && !is_drain && in_frame;
  assign v_act      = (pos_q >= three_w);
  assign o_act      = (pos_q >= lag);
  assign last0      = o_act && (out_row_q == h_m1) && (out_col_q == w_m1);

  // Position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      in_col_q  <= '0;
      in_bank_q <= '0;
      v_col_q   <= '0;
      v_row_q   <= '0;
      v_bank_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cfg_restart || (adv && last0)) begin
      pos_q     <= '0;
      in_col_q  <= '0;
      in_bank_q <= '0;
      v_col_q   <= '0;
      v_row_q   <= '0;
      v_bank_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (adv) begin
      pos_q <= pos_q + PW'(1);
      if (in_col_q == w_m1) begin
        in_col_q  <= '0;
        in_bank_q <= (in_bank_q == 3'd6) ? 3'd0 : in_bank_q + 3'd1;
      end else begin
        in_col_q <= in_col_q + CB'(1);
      end
      if (v_act) begin
        if (v_col_q == w_m1) begin
          v_col_q  <= '0;
          v_row_q  <= v_row_q + 13'd1;
          v_bank_q <= (v_bank_q == 3'd6) ? 3'd0 : v_bank_q + 3'd1;
        end else begin
          v_col_q <= v_col_q + CB'(1);
        end
      end
      if (o_act) begin
        if (out_col_q == w_m1) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + 12'd1;
        end else begin
          out_col_q <= out_col_q + CB'(1);
        end
      end
    end
  end

  // Vertical clamp: each tap row maps to the bank of its clamped row.
  always_comb begin
    int dy;
    int t;
    vlo   = (v_row_q < 13'd3) ? v_row_q[1:0] : 2'd3;
    vdiff = 13'(h_m1) - v_row_q;
    if (v_row_q > 13'(h_m1)) begin
      vhi = 2'd0;
    end else if (vdiff < 13'd3) begin
      vhi = vdiff[1:0];
    end else begin
      vhi = 2'd3;
    end
    for (int i = 0; i < NumTaps; i++) begin
      dy = i - 3;
      if (dy < -int'(vlo)) dy = -int'(vlo);
      if (dy > int'(vhi)) dy = int'(vhi);
      t = int'(v_bank_q) + dy;
      if (t < 0) t = t + 7;
      if (t > 6) t = t - 7;
      vsel[i] = 3'(t);
    end
  end

  // Horizontal clamp bounds for the output column.
  always_comb begin
    hlo   = (out_col_q < CB'(3)) ? out_col_q[1:0] : 2'd3;
    hdiff = w_m1 - out_col_q;
    hhi   = (hdiff < CB'(3)) ? hdiff[1:0] : 2'd3;
  end

  // Line store banks: the pixel goes to the bank of its row, and every bank
  // is read at the column of the vertical sum.
  assign wr_word = {in_data_i.in_alpha, in_data_i.in_blue,
                    in_data_i.in_green, in_data_i.in_red};

  for (genvar b = 0; b < NumTaps; b++) begin : g_bank
    assign bank_we[b] = wr && (in_bank_q == 3'(b));
    gb7_row_bank #(
      .Depth (MAX_WIDTH)
    ) u_bank (
      .clk_i     (clk_i),
      .wr_en_i   (bank_we[b]),
      .wr_addr_i (in_col_q),
      .wr_data_i (wr_word),
      .rd_en_i   (adv && v_act),
      .rd_addr_i (v_col_q),
      .rd_data_o (bank_rd[b])
    );
  end

  // Pipeline control, stalled as a whole while the output is held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= adv && v_act;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (adv && v_act) begin
        s1_out_q  <= o_act;
        s1_last_q <= last0;
        s1_hlo_q  <= hlo;
        s1_hhi_q  <= hhi;
        for (int i = 0; i < NumTaps; i++) begin
          s1_vsel_q[i] <= vsel[i];
        end
      end
      s2_out_q  <= s1_out_q;
      s2_last_q <= s1_last_q;
      s2_hlo_q  <= s1_hlo_q;
      s2_hhi_q  <= s1_hhi_q;
    end
  end

  // Channel lanes.
  for (genvar c = 0; c < 4; c++) begin : g_lane
    for (genvar b = 0; b < NumTaps; b++) begin : g_pix
      assign lane_pix[c][b] = bank_rd[b][8*c +: 8];
    end
    gb7_lane u_lane (
      .clk_i      (clk_i),
      .load_i     (en && s1_valid_q),
      .bank_pix_i (lane_pix[c]),
      .vsel_i     (s1_vsel_q),
      .hlo_i      (s2_hlo_q),
      .hhi_i      (s2_hhi_q),
      .res_o      (lane_res[c])
    );
  end

  // Merge stage: output register holding the combined lane results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s2_valid_q && s2_out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.out_red    <= lane_res[0];
      out_data_q.out_green  <= lane_res[1];
      out_data_q.out_blue   <= lane_res[2];
      out_data_q.out_alpha  <= four_ch ? lane_res[3] : 8'd0;
      out_data_q.frame_last <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A held result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("result dropped while stalled");

  // At most one line store bank is written per cycle.
  a_bank_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(bank_we))
    else $error("more than one bank written");

  // The frame's last output restarts the input position.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last0 |=> pos_q == '0)
    else $error("position not cleared after frame end");

  // Column counters stay inside the row.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> (in_col_q <= w_m1) && (out_col_q <= w_m1))
    else $error("column counter beyond row");

endmodule

/* verif/tb_gaussian_blur_7x7_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_blur_7x7_unit: self-checking testbench of the 7x7 binomial blur
// A directed table covers one-pixel frames in both channel modes, early drain
// beats, surplus pixel beats and out-of-range register values. Then come
// random frames of small size with random idling, one long output stall and
// noise beats. A local blur predictor works out every blurred pixel that the
// table does not give, and each output transfer is checked against its expected pixel.
// ----------------------------------------------------------------------------
module tb_gaussian_blur_7x7_unit;
  import gb7_pkg::*;

  localparam int MaxW      = 1024;
  localparam int RingDepth = 6 * MaxW + 8;
  localparam int DrainWait = 20;

  // One row of the directed table: a register write or a beat.
  typedef struct {
    bit          is_cfg;
    cfg_idx_e    reg_sel;
    logic [11:0] reg_val;
    in_t         beat;
    bit          has_exp;
    out_t        exp_px;
  } step_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [11:0] cfg_data_i;

  // Predictor state.
  logic [31:0] line_ring [RingDepth];
  logic [10:0] img_w;
  logic [11:0] img_h;
  logic [2:0]  chan_cnt;
  int unsigned in_row, in_col, out_row, out_col;
  int unsigned binom [7] = '{1, 6, 15, 20, 15, 6, 1};

  out_t        blurred_q [$];
  int          mismatches;
  int          beats_done;
  bit          calm;
  int          stall_left;
  bit          stalled_once;
  step_row_t   dir_tab [$];

  gaussian_blur_7x7_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #3ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned eff_w();
    if (img_w == 0) return 1;
    if (img_w > MaxW) return MaxW;
    return img_w;
  endfunction

  function automatic int unsigned eff_h();
    return (img_h == 0) ? 1 : img_h;
  endfunction

  function automatic void restart_counts();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
  endfunction

  // Predict the effect of one accepted beat; returns 1 when a pixel leaves.
  function automatic bit blur_beat(input in_t b, output out_t px);
    int unsigned w, h, total, pos, lag, outpos, wgt;
    int unsigned acc [4];
    int rr, cc;
    logic [31:0] word;
    w = eff_w();
    h = eff_h();
    total = w * h;
    pos = in_row * w + in_col;
    lag = 3 * w + 3;
    px = '0;
    // An early drain beat is ignored.
    if (b.opcode == OP_DRAIN && pos < total) return 1'b0;
    if (b.opcode == OP_PIXEL && pos < total)
      line_ring[pos % RingDepth] = {b.in_alpha, b.in_blue, b.in_green, b.in_red};
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    outpos = out_row * w + out_col;
    if (pos < outpos + lag) return 1'b0;
    for (int c = 0; c < 4; c++) acc[c] = 0;
    // Window taps clamp to the nearest edge pixel.
    for (int dy = -3; dy <= 3; dy++) begin
      rr = int'(out_row) + dy;
      if (rr < 0) rr = 0;
      if (rr > int'(h) - 1) rr = int'(h) - 1;
      for (int dx = -3; dx <= 3; dx++) begin
        cc = int'(out_col) + dx;
        if (cc < 0) cc = 0;
        if (cc > int'(w) - 1) cc = int'(w) - 1;
        word = line_ring[(rr * w + cc) % RingDepth];
        wgt = binom[dy + 3] * binom[dx + 3];
        for (int c = 0; c < 4; c++) acc[c] += wgt * word[8*c +: 8];
      end
    end
    px.out_red    = 8'(acc[0] >> KernShift);
    px.out_green  = 8'(acc[1] >> KernShift);
    px.out_blue   = 8'(acc[2] >> KernShift);
    px.out_alpha  = (chan_cnt >= 4) ? 8'(acc[3] >> KernShift) : 8'd0;
    px.frame_last = (outpos == total - 1);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (px.frame_last) restart_counts();
    return 1'b1;
  endfunction

  function automatic in_t mk_beat(input logic op, input logic [31:0] rgba);
    in_t b;
    b.opcode   = op;
    b.in_red   = rgba[31:24];
    b.in_green = rgba[23:16];
    b.in_blue  = rgba[15:8];
    b.in_alpha = rgba[7:0];
    return b;
  endfunction

  function automatic out_t mk_px(input logic [31:0] rgba, input logic last);
    return {rgba, last};
  endfunction

  function automatic step_row_t cfg_row(input cfg_idx_e sel, input logic [11:0] val);
    step_row_t r;
    r.is_cfg  = 1'b1;
    r.reg_sel = sel;
    r.reg_val = val;
    r.beat    = '0;
    r.has_exp = 1'b0;
    r.exp_px  = '0;
    return r;
  endfunction

  function automatic step_row_t beat_row(input logic op, input logic [31:0] rgba,
                                         input bit has, input out_t exp_px);
    step_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_sel = CFG_WIDTH;
    r.reg_val = '0;
    r.beat    = mk_beat(op, rgba);
    r.has_exp = has;
    r.exp_px  = exp_px;
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input step_row_t r);
    dir_tab = {dir_tab, r};
  endfunction

  // Wait until every blurred pixel has come, then let the pipeline settle.
  task automatic wait_idle();
    while (blurred_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Register write; the block is idle whenever this is called.
  task automatic write_reg(input cfg_idx_e sel, input logic [11:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (sel)
      CFG_WIDTH:    img_w = val[10:0];
      CFG_HEIGHT:   img_h = val;
      CFG_CHANNELS: chan_cnt = val[2:0];
      default: ;
    endcase
    restart_counts();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one beat until its transfer; optionally override the prediction.
  task automatic send_beat(input in_t b, input bit has, input out_t exp_px);
    out_t px;
    bit got;
    if (!calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    got = blur_beat(b, px);
    if (has) blurred_q = {blurred_q, exp_px};
    else if (got) blurred_q = {blurred_q, px};
    beats_done++;
    calm = (beats_done >= 1500 && beats_done < 2300);
  endtask

  task automatic send_rand(input logic op);
    send_beat(mk_beat(op, $urandom), 1'b0, '0);
  endtask

  // A whole frame: pixels then drain beats, with optional noise beats.
  task automatic send_frame(input int unsigned w, input int unsigned h, input bit noisy);
    for (int unsigned i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(99) < 4) send_rand(OP_DRAIN);
      send_rand(OP_PIXEL);
    end
    for (int unsigned i = 0; i < 3 * w + 3; i++)
      send_rand((noisy && $urandom_range(99) < 4) ? OP_PIXEL : OP_DRAIN);
  endtask

  // Output side: check each transfer and choose the next ready value.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blurred_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output pixel %h", out_data_o);
      end else begin
        out_t want;
        want = blurred_q.pop_front();
        if (out_data_o.out_red !== want.out_red ||
            out_data_o.out_green !== want.out_green ||
            out_data_o.out_blue !== want.out_blue ||
            out_data_o.out_alpha !== want.out_alpha ||
            out_data_o.frame_last !== want.frame_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected %h, got %h", want, out_data_o);
        end
      end
    end
    // One long hold-off once traffic is flowing, so the block backs up.
    if (!stalled_once && beats_done >= 300) begin
      stalled_once = 1'b1;
      stall_left = 400;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 8);
    end
  end

  // Stimulus.
  initial begin
    int unsigned w, h, nfr, cut;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    out_ready_i = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_WIDTH;
    cfg_data_i = '0;
    mismatches = 0;
    beats_done = 0;
    calm = 1'b0;
    stall_left = 0;
    stalled_once = 1'b0;
    img_w = 11'd640;
    img_h = 12'd480;
    chan_cnt = 3'd4;
    restart_counts();
    for (int i = 0; i < RingDepth; i++) line_ring[i] = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-pixel frames: the blur of a single pixel is the pixel itself.
    add_row(cfg_row(CFG_WIDTH, 12'd1));
    add_row(cfg_row(CFG_HEIGHT, 12'd1));
    add_row(cfg_row(CFG_CHANNELS, 12'd4));
    add_row(beat_row(OP_DRAIN, 32'h0, 1'b0, '0));
    add_row(beat_row(OP_PIXEL, 32'hFF00AA55, 1'b0, '0));
    for (int i = 0; i < 5; i++) add_row(beat_row(OP_DRAIN, 32'h0, 1'b0, '0));
    add_row(beat_row(OP_DRAIN, 32'h0, 1'b1, mk_px(32'hFF00AA55, 1'b1)));
    // Three channels, with a surplus pixel beat acting as the last drain.
    add_row(cfg_row(CFG_CHANNELS, 12'd3));
    add_row(beat_row(OP_PIXEL, 32'h12345678, 1'b0, '0));
    for (int i = 0; i < 5; i++) add_row(beat_row(OP_DRAIN, 32'h0, 1'b0, '0));
    add_row(beat_row(OP_PIXEL, 32'hFFFFFFFF, 1'b1, mk_px(32'h12345600, 1'b1)));
    // Zero width and height act as one; channel count zero means RGB.
    add_row(cfg_row(CFG_WIDTH, 12'd0));
    add_row(cfg_row(CFG_HEIGHT, 12'd0));
    add_row(cfg_row(CFG_CHANNELS, 12'd0));
    add_row(beat_row(OP_PIXEL, 32'h00FF00FF, 1'b0, '0));
    for (int i = 0; i < 5; i++) add_row(beat_row(OP_DRAIN, 32'h0, 1'b0, '0));
    add_row(beat_row(OP_DRAIN, 32'h0, 1'b1, mk_px(32'h00FF0000, 1'b1)));
    // Channel count seven selects RGBA; a tiny 2x2 frame via the predictor.
    add_row(cfg_row(CFG_WIDTH, 12'd2));
    add_row(cfg_row(CFG_HEIGHT, 12'd2));
    add_row(cfg_row(CFG_CHANNELS, 12'd7));
    add_row(beat_row(OP_PIXEL, 32'hFFFFFFFF, 1'b0, '0));
    add_row(beat_row(OP_PIXEL, 32'h00000000, 1'b0, '0));
    add_row(beat_row(OP_PIXEL, 32'h80808080, 1'b0, '0));
    add_row(beat_row(OP_PIXEL, 32'h7F7F7F7F, 1'b0, '0));
    for (int i = 0; i < 9; i++) add_row(beat_row(OP_DRAIN, 32'h0, 1'b0, '0));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        in_valid_i <= 1'b0;
        wait_idle();
        write_reg(dir_tab[i].reg_sel, dir_tab[i].reg_val);
      end else begin
        send_beat(dir_tab[i].beat, dir_tab[i].has_exp, dir_tab[i].exp_px);
      end
    end
    in_valid_i <= 1'b0;
    wait_idle();

    // Random phases of small frames with noise and broken frames.
    while (beats_done < 2000) begin
      case ($urandom_range(19))
        0:       write_reg(CFG_WIDTH, 12'd0);
        default: write_reg(CFG_WIDTH, 12'($urandom_range(1, 12)));
      endcase
      if ($urandom_range(19) == 0) write_reg(CFG_HEIGHT, 12'd0);
      else write_reg(CFG_HEIGHT, 12'($urandom_range(1, 8)));
      write_reg(CFG_CHANNELS, 12'($urandom_range(7)));
      w = eff_w();
      h = eff_h();
      nfr = $urandom_range(1, 3);
      for (int f = 0; f < nfr; f++) begin
        if ($urandom_range(9) == 0) begin
          // Broken frame: cut short, the next register write restarts it.
          cut = $urandom_range(1, w * h + 3 * w + 2);
          for (int unsigned i = 0; i < cut; i++)
            send_rand((i < w * h) ? OP_PIXEL : OP_DRAIN);
          break;
        end
        send_frame(w, h, 1'b1);
      end
      in_valid_i <= 1'b0;
      wait_idle();
    end

    if (mismatches == 0 && blurred_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
